[design/perspective_floor_texture_mapper_macros.svh]
// assertion macros for the perspective floor texture mapper
`ifndef PERSPECTIVE_FLOOR_TEXTURE_MAPPER_MACROS_SVH
`define PERSPECTIVE_FLOOR_TEXTURE_MAPPER_MACROS_SVH
`ifndef SYNTH
// clocked check, off while reset is asserted
`define PFTM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also holds during reset
`define PFTM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PFTM_ASSERT(lbl, clk, rst_n, prop, msg)
`define PFTM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[design/pftm_pkg.sv]
package pftm_pkg;

  // fixed field widths
  localparam int COL_W      = 10;
  localparam int ROW_W      = 10;
  localparam int ADDR_W     = 20;
  localparam int VAL_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int STORE_DEPTH = 1 << ADDR_W;

  localparam logic [VAL_W-1:0] WHITE = '1;

  // register reset values
  localparam logic [ROW_W-1:0]        HORIZON_RST = 10'd240;
  localparam logic [COL_W-1:0]        CENTRE_RST  = 10'd320;
  localparam logic signed [23:0]      CAM_X_RST   = 24'sd5120;
  localparam logic signed [23:0]      CAM_H_RST   = 24'sd2560;
  localparam logic signed [23:0]      CAM_Z_RST   = 24'sd5120;
  localparam logic signed [15:0]      COS_RST     = 16'sd16384;
  localparam logic signed [15:0]      SIN_RST     = 16'sd0;
  localparam logic [23:0]             FOCAL_RST   = 24'd51200;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HORIZON = 3'd0,
    CFG_CENTRE  = 3'd1,
    CFG_CAM_X   = 3'd2,
    CFG_CAM_H   = 3'd3,
    CFG_CAM_Z   = 3'd4,
    CFG_COS     = 3'd5,
    CFG_SIN     = 3'd6,
    CFG_FOCAL   = 3'd7
  } cfg_idx_e;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_RENDER = 1'b1
  } opcode_e;

  typedef struct packed {
    logic              opcode;
    logic [COL_W-1:0]  pixel_column;
    logic [ROW_W-1:0]  pixel_row;
    logic [ADDR_W-1:0] texel_address;
    logic [VAL_W-1:0]  texel_value;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] pixel_colour;
    logic             background;
  } out_item_t;

endpackage

[design/pftm_in_if.sv]
interface pftm_in_if
  import pftm_pkg::*;
  ();
  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

[design/pftm_out_if.sv]
interface pftm_out_if
  import pftm_pkg::*;
  ();
  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

[design/pftm_ram.sv]
module pftm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[design/perspective_floor_texture_mapper.sv]
// Perspective floor texture mapper. Write beats (opcode 0) store one texel in a
// 1M x 32 texture RAM; render beats (opcode 1) project a screen pixel below the
// horizon onto the floor plane and return the texel it lands on, or opaque white
// with the background flag when it misses the texture, lies off the screen or
// sits at or above the horizon. Write beats return nothing. The block takes one
// beat per clock and keeps going while a result waits at the output, as long as
// the pipeline has a free slot. A beat passes through five arithmetic stages, a
// Q-stage restoring divider that yields one quotient bit per stage for each
// coordinate, where Q is the ceiling of log2 of the larger texture dimension,
// the address stage, the texture RAM read, which registers together with the
// result flags, and the output handshake. Writes pass through the same pipeline,
// so reads and writes reach the RAM in the order the beats arrived. Texels must
// be written before they are read. Register writes apply to beats accepted on
// the following cycle.
`include "perspective_floor_texture_mapper_macros.svh"

module perspective_floor_texture_mapper
  import pftm_pkg::*;
#(
  parameter int TEX_WIDTH     = 1024,
  parameter int TEX_HEIGHT    = 1024,
  parameter int SCREEN_WIDTH  = 1024,
  parameter int SCREEN_HEIGHT = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  pftm_in_if.sink               in_i,
  pftm_out_if.source            out_o
);

  localparam int QW  = ($clog2(TEX_WIDTH) > $clog2(TEX_HEIGHT)) ?
                       $clog2(TEX_WIDTH) : $clog2(TEX_HEIGHT);
  localparam int NW  = QW + ROW_W;
  localparam int NS  = QW + 6;
  localparam int SM  = NS - 1;
  localparam int SD0 = 4;

  typedef struct packed {
    opcode_e           op;
    logic              bg;
    logic [ROW_W-1:0]  dy;
    logic [ADDR_W-1:0] taddr;
    logic [VAL_W-1:0]  tval;
  } base_t;

  typedef struct packed {
    base_t        base;
    logic [10:0]  dx;
  } sa_t;

  typedef struct packed {
    base_t          base;
    logic [50:0]    ax;
    logic [50:0]    az;
    logic [34:0]    ex;
    logic [34:0]    ez;
    logic [NW-1:0]  limx;
    logic [NW-1:0]  limz;
  } sb_t;

  typedef struct packed {
    base_t          base;
    logic [63:0]    px;
    logic [63:0]    pz;
    logic [NW-1:0]  limx;
    logic [NW-1:0]  limz;
  } sc_t;

  typedef struct packed {
    base_t          base;
    logic [33:0]    tx;
    logic [33:0]    tz;
    logic [NW-1:0]  limx;
    logic [NW-1:0]  limz;
  } sd_t;

  typedef struct packed {
    base_t          base;
    logic [NW-1:0]  rx;
    logic [NW-1:0]  rz;
    logic [QW-1:0]  qx;
    logic [QW-1:0]  qz;
  } div_t;

  typedef struct packed {
    opcode_e           op;
    logic              bg;
    logic [ADDR_W-1:0] maddr;
    logic [VAL_W-1:0]  tval;
  } sm_t;

  // configuration registers
  logic [ROW_W-1:0]   horizon_q;
  logic [COL_W-1:0]   centre_q;
  logic signed [23:0] cam_x_q, cam_h_q, cam_z_q;
  logic signed [15:0] cos_q, sin_q;
  logic [23:0]        focal_q;

  // view products that depend on registers only
  logic signed [39:0] hc_q, hs_q;
  logic signed [47:0] dh_q;
  logic signed [40:0] dhs_lo_q, dhc_lo_q;
  logic signed [39:0] dhs_hi_q, dhc_hi_q;
  logic signed [63:0] dhs_q, dhc_q;

  // pipeline
  logic [NS-1:0] v_q;
  logic [NS-1:0] free;
  logic          free_o;
  sa_t           sa_d, sa_q;
  sb_t           sb_d, sb_q;
  sc_t           sc_d, sc_q;
  sd_t           sd_d, sd_q;
  div_t          dv_d [QW+1];
  div_t          dv_q [QW+1];
  sm_t           sm_d, sm_q;
  logic          out_valid_q;
  logic          out_bg_q;

  logic          ram_we, ram_re;
  logic [VAL_W-1:0] ram_rdata;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      horizon_q <= HORIZON_RST;
      centre_q  <= CENTRE_RST;
      cam_x_q   <= CAM_X_RST;
      cam_h_q   <= CAM_H_RST;
      cam_z_q   <= CAM_Z_RST;
      cos_q     <= COS_RST;
      sin_q     <= SIN_RST;
      focal_q   <= FOCAL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_HORIZON: horizon_q <= cfg_wdata_i[ROW_W-1:0];
        CFG_CENTRE:  centre_q  <= cfg_wdata_i[COL_W-1:0];
        CFG_CAM_X:   cam_x_q   <= $signed(cfg_wdata_i);
        CFG_CAM_H:   cam_h_q   <= $signed(cfg_wdata_i);
        CFG_CAM_Z:   cam_z_q   <= $signed(cfg_wdata_i);
        CFG_COS:     cos_q     <= $signed(cfg_wdata_i[15:0]);
        CFG_SIN:     sin_q     <= $signed(cfg_wdata_i[15:0]);
        CFG_FOCAL:   focal_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // height times trig, and focal times height times trig in split halves
  always_ff @(posedge clk_i) begin
    hc_q     <= cam_h_q * cos_q;
    hs_q     <= cam_h_q * sin_q;
    dh_q     <= $signed({1'b0, focal_q}) * cam_h_q;
    dhs_lo_q <= $signed({1'b0, dh_q[23:0]}) * sin_q;
    dhc_lo_q <= $signed({1'b0, dh_q[23:0]}) * cos_q;
    dhs_hi_q <= $signed(dh_q[47:24]) * sin_q;
    dhc_hi_q <= $signed(dh_q[47:24]) * cos_q;
    dhs_q    <= (64'(dhs_hi_q) <<< 24) + 64'(dhs_lo_q);
    dhc_q    <= (64'(dhc_hi_q) <<< 24) + 64'(dhc_lo_q);
  end

  // stall chain: a stage loads when it is empty or its content moves on
  always_comb begin
    free_o        = !out_valid_q || out_o.ready;
    free[NS-1]    = !v_q[NS-1] || free_o;
    for (int k = NS - 2; k >= 0; k--) begin
      free[k] = !v_q[k] || free[k+1];
    end
  end

  assign in_i.ready = free[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (free[0]) begin
        v_q[0] <= in_i.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (free[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
      if (free_o) begin
        out_valid_q <= v_q[SM] && (sm_q.op == OP_RENDER);
      end
    end
  end

  // stage a: screen offsets and horizon test
  always_comb begin
    sa_d.base.op    = opcode_e'(in_i.item.opcode);
    sa_d.base.bg    = (int'(in_i.item.pixel_column) >= SCREEN_WIDTH) ||
                      (int'(in_i.item.pixel_row) >= SCREEN_HEIGHT) ||
                      (in_i.item.pixel_row <= horizon_q);
    sa_d.base.dy    = in_i.item.pixel_row - horizon_q;
    sa_d.base.taddr = in_i.item.texel_address;
    sa_d.base.tval  = in_i.item.texel_value;
    sa_d.dx         = $signed({1'b0, in_i.item.pixel_column}) -
                      $signed({1'b0, centre_q});
  end

  // stage b: per-pixel products
  always_comb begin
    sb_d.base = sa_q.base;
    sb_d.ax   = hc_q * $signed(sa_q.dx);
    sb_d.az   = hs_q * $signed(sa_q.dx);
    sb_d.ex   = cam_x_q * $signed({1'b0, sa_q.base.dy});
    sb_d.ez   = cam_z_q * $signed({1'b0, sa_q.base.dy});
    sb_d.limx = NW'(sa_q.base.dy) * NW'(TEX_WIDTH);
    sb_d.limz = NW'(sa_q.base.dy) * NW'(TEX_HEIGHT);
  end

  // stage c: camera and lateral terms aligned to q30
  always_comb begin
    sc_d.base = sb_q.base;
    sc_d.px   = (64'($signed(sb_q.ex)) <<< 22) + (64'($signed(sb_q.ax)) <<< 8);
    sc_d.pz   = (64'($signed(sb_q.ez)) <<< 22) + (64'($signed(sb_q.az)) <<< 8);
    sc_d.limx = sb_q.limx;
    sc_d.limz = sb_q.limz;
  end

  // stage d: add the forward term, drop the q30 fraction by flooring
  logic signed [63:0] nx, nz;
  always_comb begin
    nx        = $signed(sc_q.px) + dhs_q;
    nz        = $signed(sc_q.pz) - dhc_q;
    sd_d.base = sc_q.base;
    sd_d.tx   = nx[63:30];
    sd_d.tz   = nz[63:30];
    sd_d.limx = sc_q.limx;
    sd_d.limz = sc_q.limz;
  end

  logic okx, okz;
  always_comb begin
    logic [NW-1:0] dsh;
    dsh = '0;
    // stage e: bounds test, quotient must land in [0, size)
    okx = !sd_q.tx[33] && (sd_q.tx < 34'(sd_q.limx));
    okz = !sd_q.tz[33] && (sd_q.tz < 34'(sd_q.limz));
    dv_d[0]         = '0;
    dv_d[0].base    = sd_q.base;
    dv_d[0].base.bg = sd_q.base.bg || !(okx && okz);
    dv_d[0].rx      = sd_q.tx[NW-1:0];
    dv_d[0].rz      = sd_q.tz[NW-1:0];
    dv_d[0].qx      = '0;
    dv_d[0].qz      = '0;
    // restoring divider, one quotient bit per stage, msb first
    for (int k = 0; k < QW; k++) begin
      dsh        = NW'(dv_q[k].base.dy) << (QW - 1 - k);
      dv_d[k+1]  = dv_q[k];
      if (dv_q[k].rx >= dsh) begin
        dv_d[k+1].rx             = dv_q[k].rx - dsh;
        dv_d[k+1].qx[QW - 1 - k] = 1'b1;
      end
      if (dv_q[k].rz >= dsh) begin
        dv_d[k+1].rz             = dv_q[k].rz - dsh;
        dv_d[k+1].qz[QW - 1 - k] = 1'b1;
      end
    end
  end

  // address stage: texel row times width plus column
  logic [31:0] tex_lin;
  always_comb begin
    tex_lin    = 32'(dv_q[QW].qz) * 32'(TEX_WIDTH) + 32'(dv_q[QW].qx);
    sm_d.op    = dv_q[QW].base.op;
    sm_d.bg    = dv_q[QW].base.bg;
    sm_d.tval  = dv_q[QW].base.tval;
    sm_d.maddr = (dv_q[QW].base.op == OP_WRITE) ? dv_q[QW].base.taddr :
                 tex_lin[ADDR_W-1:0];
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (free[0]) sa_q <= sa_d;
    if (free[1]) sb_q <= sb_d;
    if (free[2]) sc_q <= sc_d;
    if (free[3]) sd_q <= sd_d;
    for (int k = 0; k <= QW; k++) begin
      if (free[SD0 + k]) begin
        dv_q[k] <= dv_d[k];
      end
    end
    if (free[SM]) sm_q <= sm_d;
    if (free_o) out_bg_q <= sm_q.bg;
  end

  // texture RAM access
  assign ram_we = free_o && v_q[SM] && (sm_q.op == OP_WRITE);
  assign ram_re = free_o && v_q[SM] && (sm_q.op == OP_RENDER) && !sm_q.bg;

  pftm_ram #(
    .WIDTH (VAL_W),
    .DEPTH (STORE_DEPTH)
  ) u_tex_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (sm_q.maddr),
    .wdata_i (sm_q.tval),
    .re_i    (ram_re),
    .raddr_i (sm_q.maddr),
    .rdata_o (ram_rdata)
  );

  // result beat
  assign out_o.valid             = out_valid_q;
  assign out_o.item.background   = out_bg_q;
  assign out_o.item.pixel_colour = out_bg_q ? WHITE : ram_rdata;

  // checks
  `PFTM_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> !out_valid_q && (v_q == '0), "pipeline not empty in reset")
  `PFTM_ASSERT(a_write_silent, clk_i, rst_ni, ram_we |=> !out_valid_q, "write beat produced a result")
  `PFTM_ASSERT(a_stall_full, clk_i, rst_ni, !in_i.ready |-> (&v_q) && out_valid_q, "input stalled with a free slot")
  `PFTM_ASSERT(a_div_rem, clk_i, rst_ni, (v_q[SM-1] && (dv_q[QW].base.op == OP_RENDER) && !dv_q[QW].base.bg) |-> (dv_q[QW].rx < NW'(dv_q[QW].base.dy)) && (dv_q[QW].rz < NW'(dv_q[QW].base.dy)), "divider remainder not reduced")

endmodule
